// ----- rtl/dss_pkg.sv -----
// Shared types and constants for the discrete state-space system block.
package dss_pkg;

    // Request kinds
    localparam logic KIND_COEF   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_STATES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUTS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUTS = 2'd2;

    // Cycles from term issue to accumulator write-back
    localparam int MAC_LAT = 3;

    // One request: coefficient write or input sample
    typedef struct packed {
        logic               kind;
        logic [7:0]         coef_index;
        logic signed [31:0] value;
        logic               last_input;
    } req_t;

    // One result: element of y
    typedef struct packed {
        logic [1:0]         out_index;
        logic signed [31:0] out_value;
        logic               last_output;
    } res_t;

    // Control that travels with one product term
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic dummy;
        logic from_input;
        logic state_ok;
        logic to_output;
    } term_t;

    // Finished dot product
    typedef struct packed {
        logic valid;
        logic to_output;
    } wb_t;

endpackage

// ----- rtl/discrete_state_space_system.sv -----
// Top level of the discrete state-space system: ports, registers, memories, input buffer.
//
//  Channel   Signals                                   Handshake
//  request   start, busy, request (dss_pkg::req_t)     taken when start && !busy
//  result    result_valid, result (dss_pkg::res_t)     one-cycle strobe, no back-pressure
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data taken when cfg_valid && cfg_ready
//
// A coefficient request or a sample that does not close a step leaves busy low.
// A closing sample runs ny + nx rows of max(nx + nu, 1) multiply-accumulate terms on the
// single MAC pipeline, then drains it; busy is high for that whole span.
// With nx and ny both zero a closing sample has nothing to compute and busy stays low.
// Results appear while the C and D rows finish, one per row, before the state update.
// Reset clears the state vector through per-entry valid bits; no clearing pass is needed.
module discrete_state_space_system #(
    parameter int MAX_STATES  = 8,
    parameter int MAX_INPUTS  = 4,
    parameter int MAX_OUTPUTS = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  dss_pkg::req_t                    request,
    output logic                             result_valid,
    output dss_pkg::res_t                    result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dss_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int DEPTH = MAX_STATES*MAX_STATES + MAX_STATES*MAX_INPUTS
                         + MAX_OUTPUTS*MAX_STATES + MAX_OUTPUTS*MAX_INPUTS;
    localparam int AW   = $clog2(DEPTH);
    localparam int JW   = MAX_STATES > 1 ? $clog2(MAX_STATES) : 1;
    localparam int SD   = 2 * (2 ** JW);
    localparam int KW   = MAX_INPUTS > 1 ? $clog2(MAX_INPUTS) : 1;
    localparam int RMAX = MAX_STATES > MAX_OUTPUTS ? MAX_STATES : MAX_OUTPUTS;
    localparam int RW   = RMAX > 1 ? $clog2(RMAX) : 1;
    localparam int NXW  = $clog2(MAX_STATES+1);
    localparam int NUW  = $clog2(MAX_INPUTS+1);
    localparam int NYW  = $clog2(MAX_OUTPUTS+1);

    logic [3:0]         states_reg;
    logic [2:0]         inputs_reg;
    logic [2:0]         outputs_reg;
    logic [NXW-1:0]     nx;
    logic [NUW-1:0]     nu;
    logic [NYW-1:0]     ny;

    logic [NUW-1:0]     count_reg;
    logic signed [31:0] in_buf_reg [MAX_INPUTS];

    logic               accept;
    logic               coef_we;
    logic               trigger;

    logic [AW-1:0]      coef_raddr;
    logic [31:0]        coef_rdata;
    logic [JW:0]        st_raddr;
    logic [JW:0]        st_waddr;
    logic               st_we;
    logic [31:0]        st_rdata;
    logic [KW-1:0]      k_index;
    logic signed [31:0] u_sel;
    dss_pkg::term_t     term;
    logic [RW-1:0]      row;
    dss_pkg::wb_t       wb;
    logic [RW-1:0]      wb_row;
    logic signed [31:0] wb_data;

    logic               result_valid_reg;
    dss_pkg::res_t      result_reg;

    // Configuration registers; the port never stalls
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            states_reg  <= 4'd8;
            inputs_reg  <= 3'd4;
            outputs_reg <= 3'd4;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dss_pkg::CFG_STATES:  states_reg  <= cfg_data[3:0];
                dss_pkg::CFG_INPUTS:  inputs_reg  <= cfg_data[2:0];
                dss_pkg::CFG_OUTPUTS: outputs_reg <= cfg_data[2:0];
                default:
                begin
                end
            endcase
        end
    end

    // Clamp sizes to the built maxima
    assign nx = (int'(states_reg)  > MAX_STATES)  ? NXW'(MAX_STATES)  : NXW'(states_reg);
    assign nu = (int'(inputs_reg)  > MAX_INPUTS)  ? NUW'(MAX_INPUTS)  : NUW'(inputs_reg);
    assign ny = (int'(outputs_reg) > MAX_OUTPUTS) ? NYW'(MAX_OUTPUTS) : NYW'(outputs_reg);

    // Decode the request
    assign accept  = start && !busy;
    assign coef_we = accept && (request.kind == dss_pkg::KIND_COEF)
                     && (int'(request.coef_index) < DEPTH);
    assign trigger = accept && (request.kind == dss_pkg::KIND_SAMPLE) && request.last_input;

    // Collect input samples; drop extras beyond nu
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept && request.kind == dss_pkg::KIND_SAMPLE)
        begin
            if (request.last_input)
            begin
                count_reg <= '0;
            end
            else if (count_reg < nu)
            begin
                count_reg <= count_reg + NUW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && request.kind == dss_pkg::KIND_SAMPLE && count_reg < nu)
        begin
            in_buf_reg[KW'(count_reg)] <= request.value;
        end
    end

    assign u_sel = in_buf_reg[k_index];

    // Coefficient store
    dss_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (AW'(request.coef_index)),
        .wdata (request.value),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    // State vector, two banks per entry
    dss_ram #(
        .WIDTH (32),
        .DEPTH (SD)
    ) u_state_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (wb_data),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    dss_seq #(
        .MAX_STATES  (MAX_STATES),
        .MAX_INPUTS  (MAX_INPUTS),
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .trigger    (trigger),
        .nx         (nx),
        .nu         (nu),
        .ny         (ny),
        .busy       (busy),
        .coef_raddr (coef_raddr),
        .st_raddr   (st_raddr),
        .k_index    (k_index),
        .term       (term),
        .row        (row),
        .wb         (wb),
        .wb_row     (wb_row),
        .st_we      (st_we),
        .st_waddr   (st_waddr)
    );

    dss_mac #(
        .RW (RW)
    ) u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .term        (term),
        .row         (row),
        .u_value     (u_sel),
        .coef        (coef_rdata),
        .state_value (st_rdata),
        .wb          (wb),
        .wb_row      (wb_row),
        .wb_data     (wb_data)
    );

    // Output register: strobe each finished y element
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= wb.valid && wb.to_output;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wb.valid && wb.to_output)
        begin
            result_reg.out_index   <= 2'(wb_row);
            result_reg.out_value   <= wb_data;
            result_reg.last_output <= (int'(wb_row) + 1 == int'(ny));
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- rtl/dss_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module dss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/dss_mac.sv -----
// Multiply-accumulate pipeline with 64-bit saturating sum and Q16.16 round/saturate.
module dss_mac #(
    parameter int RW = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dss_pkg::term_t      term,
    input  logic [RW-1:0]       row,
    input  logic signed [31:0]  u_value,
    input  logic [31:0]         coef,
    input  logic [31:0]         state_value,
    output dss_pkg::wb_t        wb,
    output logic [RW-1:0]       wb_row,
    output logic signed [31:0]  wb_data
);

    dss_pkg::term_t     s1_term_reg;
    logic [RW-1:0]      s1_row_reg;
    logic signed [31:0] s1_u_reg;

    dss_pkg::term_t     s2_term_reg;
    logic [RW-1:0]      s2_row_reg;
    logic signed [63:0] s2_prod_reg;

    dss_pkg::term_t     s3_term_reg;
    logic [RW-1:0]      s3_row_reg;
    logic signed [63:0] acc_reg;

    logic signed [31:0] operand_b;
    logic signed [63:0] prod_next;
    logic signed [64:0] sum_wide;
    logic signed [63:0] acc_next;
    logic signed [48:0] rounded;

    // Stage 1: capture control while the memories read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_term_reg <= '0;
        end
        else
        begin
            s1_term_reg <= term;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_row_reg <= row;
        s1_u_reg   <= u_value;
    end

    // Select the second operand; unused state and empty rows give zero
    always_comb
    begin
        if (s1_term_reg.dummy)
        begin
            operand_b = '0;
        end
        else if (s1_term_reg.from_input)
        begin
            operand_b = s1_u_reg;
        end
        else if (s1_term_reg.state_ok)
        begin
            operand_b = $signed(state_value);
        end
        else
        begin
            operand_b = '0;
        end
        prod_next = $signed(coef) * operand_b;
    end

    // Stage 2: register the product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_term_reg <= '0;
        end
        else
        begin
            s2_term_reg <= s1_term_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_row_reg  <= s1_row_reg;
        s2_prod_reg <= prod_next;
    end

    // Saturating accumulate, restarting on the first term of a row
    always_comb
    begin
        sum_wide = {acc_reg[63], acc_reg} + {s2_prod_reg[63], s2_prod_reg};
        if (s2_term_reg.first)
        begin
            acc_next = s2_prod_reg;
        end
        else if (sum_wide[64] != sum_wide[63])
        begin
            acc_next = sum_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        else
        begin
            acc_next = sum_wide[63:0];
        end
    end

    // Stage 3: accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_term_reg <= '0;
        end
        else
        begin
            s3_term_reg <= s2_term_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_term_reg.valid)
        begin
            acc_reg    <= acc_next;
            s3_row_reg <= s2_row_reg;
        end
    end

    // Round half up at bit 15, then clamp to 32 bits
    always_comb
    begin
        rounded = {acc_reg[63], acc_reg[63:16]} + 49'(acc_reg[15]);
        if (rounded > 49'sd2147483647)
        begin
            wb_data = 32'sh7fffffff;
        end
        else if (rounded < -49'sd2147483648)
        begin
            wb_data = 32'sh80000000;
        end
        else
        begin
            wb_data = rounded[31:0];
        end
    end

    assign wb.valid     = s3_term_reg.valid && s3_term_reg.last;
    assign wb.to_output = s3_term_reg.to_output;
    assign wb_row       = s3_row_reg;

endmodule

// ----- rtl/dss_seq.sv -----
// Step sequencer: walks rows and terms, generates store addresses, owns state banks.
module dss_seq #(
    parameter int MAX_STATES  = 8,
    parameter int MAX_INPUTS  = 4,
    parameter int MAX_OUTPUTS = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  logic trigger,
    input  logic [$clog2(MAX_STATES+1)-1:0]  nx,
    input  logic [$clog2(MAX_INPUTS+1)-1:0]  nu,
    input  logic [$clog2(MAX_OUTPUTS+1)-1:0] ny,
    output logic busy,
    output logic [$clog2(MAX_STATES*MAX_STATES + MAX_STATES*MAX_INPUTS
                 + MAX_OUTPUTS*MAX_STATES + MAX_OUTPUTS*MAX_INPUTS)-1:0] coef_raddr,
    output logic [(MAX_STATES > 1 ? $clog2(MAX_STATES) : 1):0]      st_raddr,
    output logic [(MAX_INPUTS > 1 ? $clog2(MAX_INPUTS) : 1)-1:0]    k_index,
    output dss_pkg::term_t term,
    output logic [(MAX_STATES > MAX_OUTPUTS ?
                   (MAX_STATES > 1 ? $clog2(MAX_STATES) : 1) :
                   (MAX_OUTPUTS > 1 ? $clog2(MAX_OUTPUTS) : 1))-1:0] row,
    input  dss_pkg::wb_t wb,
    input  logic [(MAX_STATES > MAX_OUTPUTS ?
                   (MAX_STATES > 1 ? $clog2(MAX_STATES) : 1) :
                   (MAX_OUTPUTS > 1 ? $clog2(MAX_OUTPUTS) : 1))-1:0] wb_row,
    output logic st_we,
    output logic [(MAX_STATES > 1 ? $clog2(MAX_STATES) : 1):0]      st_waddr
);

    localparam int DEPTH = MAX_STATES*MAX_STATES + MAX_STATES*MAX_INPUTS
                         + MAX_OUTPUTS*MAX_STATES + MAX_OUTPUTS*MAX_INPUTS;
    localparam int AW  = $clog2(DEPTH);
    localparam int JW  = MAX_STATES > 1 ? $clog2(MAX_STATES) : 1;
    localparam int KW  = MAX_INPUTS > 1 ? $clog2(MAX_INPUTS) : 1;
    localparam int RMAX = MAX_STATES > MAX_OUTPUTS ? MAX_STATES : MAX_OUTPUTS;
    localparam int RW  = RMAX > 1 ? $clog2(RMAX) : 1;
    localparam int NXW = $clog2(MAX_STATES+1);
    localparam int NUW = $clog2(MAX_INPUTS+1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic                  is_y_reg, is_y_next;
    logic [RW-1:0]         row_reg, row_next;
    logic [JW-1:0]         j_reg, j_next;
    logic [KW-1:0]         k_reg, k_next;
    logic                  inp_reg, inp_next;
    logic                  first_reg, first_next;
    logic [AW-1:0]         addr_reg, addr_next;
    logic [1:0]            drain_reg, drain_next;
    logic [MAX_STATES-1:0] bank_reg, bank_next;
    logic [MAX_STATES-1:0] valid_reg, valid_next;

    logic [AW-1:0] lb, lc, ld, stride;
    logic          nt_zero, last_term, row_last, last_state_term, new_row;
    logic [JW-1:0] wb_j;

    // Section bases of the packed A, B, C, D store
    always_comb
    begin
        lb       = AW'(nx) * AW'(nx);
        lc       = lb + AW'(nx) * AW'(nu);
        ld       = lc + AW'(ny) * AW'(nx);
        stride   = is_y_reg ? AW'(ny) : AW'(nx);
        nt_zero  = (nx == '0) && (nu == '0);
        last_state_term = (NXW'(j_reg) + NXW'(1)) == nx;
        last_term = nt_zero ||
                    (inp_reg ? ((NUW'(k_reg) + NUW'(1)) == nu)
                             : (last_state_term && nu == '0));
        row_last = is_y_reg ? (int'(row_reg) + 1 == int'(ny))
                            : (int'(row_reg) + 1 == int'(nx));
    end

    // Row and term walk
    always_comb
    begin
        state_next = state_reg;
        is_y_next  = is_y_reg;
        row_next   = row_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        inp_next   = inp_reg;
        first_next = first_reg;
        addr_next  = addr_reg;
        drain_next = drain_reg;
        bank_next  = bank_reg;
        valid_next = valid_reg;
        new_row    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (trigger)
                begin
                    if (ny != '0)
                    begin
                        state_next = ST_RUN;
                        is_y_next  = 1'b1;
                        row_next   = '0;
                        new_row    = 1'b1;
                    end
                    else if (nx != '0)
                    begin
                        state_next = ST_RUN;
                        is_y_next  = 1'b0;
                        row_next   = '0;
                        new_row    = 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                first_next = 1'b0;
                if (last_term)
                begin
                    if (!row_last)
                    begin
                        row_next = row_reg + RW'(1);
                        new_row  = 1'b1;
                    end
                    else if (is_y_reg && nx != '0)
                    begin
                        is_y_next = 1'b0;
                        row_next  = '0;
                        new_row   = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_DRAIN;
                        drain_next = '0;
                    end
                end
                else if (!inp_reg && last_state_term)
                begin
                    inp_next  = 1'b1;
                    k_next    = '0;
                    addr_next = (is_y_reg ? ld : lb) + AW'(row_reg);
                end
                else if (!inp_reg)
                begin
                    j_next    = j_reg + JW'(1);
                    addr_next = addr_reg + stride;
                end
                else
                begin
                    k_next    = k_reg + KW'(1);
                    addr_next = addr_reg + stride;
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + 2'd1;
                if (int'(drain_reg) == dss_pkg::MAC_LAT - 1)
                begin
                    state_next = ST_IDLE;
                    for (int i = 0; i < MAX_STATES; i++)
                    begin
                        if (i < int'(nx))
                        begin
                            bank_next[i]  = ~bank_reg[i];
                            valid_next[i] = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Start a row at its first coefficient
        if (new_row)
        begin
            j_next     = '0;
            k_next     = '0;
            first_next = 1'b1;
            inp_next   = (nx == '0);
            if (is_y_next)
            begin
                addr_next = ((nx == '0) ? ld : lc) + AW'(row_next);
            end
            else
            begin
                addr_next = AW'(row_next);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bank_reg  <= '0;
            valid_reg <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bank_reg  <= bank_next;
            valid_reg <= valid_next;
            drain_reg <= drain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_y_reg  <= is_y_next;
        row_reg   <= row_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        inp_reg   <= inp_next;
        first_reg <= first_next;
        addr_reg  <= addr_next;
    end

    // Issue one term per cycle
    assign busy       = (state_reg != ST_IDLE);
    assign coef_raddr = addr_reg;
    assign st_raddr   = {bank_reg[j_reg], j_reg};
    assign k_index    = k_reg;
    assign row        = row_reg;

    always_comb
    begin
        term.valid      = (state_reg == ST_RUN);
        term.first      = first_reg;
        term.last       = last_term;
        term.dummy      = nt_zero;
        term.from_input = inp_reg;
        term.state_ok   = valid_reg[j_reg];
        term.to_output  = is_y_reg;
    end

    // Write new state into the idle bank
    assign wb_j     = JW'(wb_row);
    assign st_we    = wb.valid && !wb.to_output;
    assign st_waddr = {~bank_reg[wb_j], wb_j};

endmodule

// ----- verif/dss_output_check.sv -----
// Output checker for the state-space block: tracks x, u and coefficients, predicts y, compares.
module dss_output_check (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  dss_pkg::req_t                    request,
    input  logic                             result_valid,
    input  dss_pkg::res_t                    result,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [dss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dss_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                               pending,
    output int                               fail_count
);

    localparam int NX_MAX      = 8;
    localparam int NU_MAX      = 4;
    localparam int NY_MAX      = 4;
    localparam int STORE_DEPTH = NX_MAX * NX_MAX + NX_MAX * NU_MAX
                               + NY_MAX * NX_MAX + NY_MAX * NU_MAX;

    logic signed [31:0] coef_mem [STORE_DEPTH];
    logic signed [31:0] x_vec [NX_MAX];
    logic signed [31:0] u_buf [NU_MAX];
    int unsigned        u_count;
    logic [3:0]         states_reg;
    logic [2:0]         inputs_reg;
    logic [2:0]         outputs_reg;
    dss_pkg::res_t      y_queue [$];
    int                 errors;

    // Register values above the maximum act as the maximum
    function automatic int unsigned size_of(input int unsigned raw, input int unsigned top);
        return (raw > top) ? top : raw;
    endfunction

    // Add one exact Q32.32 product, saturating at the 64-bit bounds
    function automatic longint sat_mac(input longint acc, input logic signed [31:0] a,
                                       input logic signed [31:0] b);
        longint prod;
        longint sum;
        prod = longint'(a) * longint'(b);
        sum  = acc + prod;
        if (acc[63] == prod[63] && sum[63] != acc[63])
            return acc[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return sum;
    endfunction

    // Round half up to Q16.16, then clamp to 32 bits
    function automatic logic signed [31:0] round_q16(input longint acc);
        longint q;
        q = acc >>> 16;
        if (acc[15])
            q = q + 1;
        if (q > 64'sh7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        if (q < -64'sh8000_0000)
            return 32'sh8000_0000;
        return q[31:0];
    endfunction

    // Close a step: queue y = C*x + D*u, then advance x = A*x + B*u from the old x
    task automatic close_step();
        int unsigned        nx;
        int unsigned        nu;
        int unsigned        ny;
        int unsigned        lb;
        int unsigned        lc;
        int unsigned        ld;
        longint             acc;
        logic signed [31:0] x_next [NX_MAX];
        dss_pkg::res_t      y;
        nx = size_of(states_reg, NX_MAX);
        nu = size_of(inputs_reg, NU_MAX);
        ny = size_of(outputs_reg, NY_MAX);
        lb = nx * nx;
        lc = lb + nx * nu;
        ld = lc + ny * nx;
        for (int unsigned i = 0; i < ny; i++)
        begin
            acc = 0;
            for (int unsigned j = 0; j < nx; j++)
                acc = sat_mac(acc, coef_mem[lc + i + j * ny], x_vec[j]);
            for (int unsigned k = 0; k < nu; k++)
                acc = sat_mac(acc, coef_mem[ld + i + k * ny], u_buf[k]);
            y.out_index   = 2'(i);
            y.out_value   = round_q16(acc);
            y.last_output = (i == ny - 1);
            y_queue.push_back(y);
        end
        for (int unsigned i = 0; i < nx; i++)
        begin
            acc = 0;
            for (int unsigned j = 0; j < nx; j++)
                acc = sat_mac(acc, coef_mem[i + j * nx], x_vec[j]);
            for (int unsigned k = 0; k < nu; k++)
                acc = sat_mac(acc, coef_mem[lb + i + k * nx], u_buf[k]);
            x_next[i] = round_q16(acc);
        end
        for (int unsigned i = 0; i < nx; i++)
            x_vec[i] = x_next[i];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        dss_pkg::res_t want;
        if (!rst_n)
        begin
            states_reg  = 4'd8;
            inputs_reg  = 3'd4;
            outputs_reg = 3'd4;
            u_count     = 0;
            errors      = 0;
            for (int i = 0; i < NX_MAX; i++)
                x_vec[i] = '0;
            y_queue.delete();
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            // Compare each result against the oldest prediction
            if (result_valid)
            begin
                if (y_queue.size() == 0)
                begin
                    $error("result with no request outstanding: out_index %0d out_value %0d",
                           result.out_index, result.out_value);
                    errors++;
                end
                else
                begin
                    want = y_queue.pop_front();
                    if (result.out_index !== want.out_index)
                    begin
                        $error("out_index: expected %0d, got %0d",
                               want.out_index, result.out_index);
                        errors++;
                    end
                    if (result.out_value !== want.out_value)
                    begin
                        $error("out_value: expected %0d, got %0d",
                               want.out_value, result.out_value);
                        errors++;
                    end
                    if (result.last_output !== want.last_output)
                    begin
                        $error("last_output: expected %0d, got %0d",
                               want.last_output, result.last_output);
                        errors++;
                    end
                end
            end

            // Track register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    dss_pkg::CFG_STATES:  states_reg  = cfg_data[3:0];
                    dss_pkg::CFG_INPUTS:  inputs_reg  = cfg_data[2:0];
                    dss_pkg::CFG_OUTPUTS: outputs_reg = cfg_data[2:0];
                    default:              ;
                endcase
            end

            // Apply an accepted request
            if (start && !busy)
            begin
                if (request.kind == dss_pkg::KIND_COEF)
                begin
                    if (request.coef_index < STORE_DEPTH)
                        coef_mem[request.coef_index] = request.value;
                end
                else
                begin
                    if (u_count < size_of(inputs_reg, NU_MAX))
                    begin
                        u_buf[u_count] = request.value;
                        u_count++;
                    end
                    if (request.last_input)
                    begin
                        u_count = 0;
                        close_step();
                    end
                end
            end

            pending    <= y_queue.size();
            fail_count <= errors;
        end
    end

endmodule

// ----- verif/tb_discrete_state_space_system.sv -----
// Testbench top for the state-space block: reset, stimulus phases, watchdog and verdict.
module tb_discrete_state_space_system;

    localparam int STORE_DEPTH     = 144;
    localparam int ITEMS_PER_PHASE = 18;
    localparam int NUM_SETTINGS    = 11;
    // Drain pause after the last result, longer than the longest closing step
    localparam int DRAIN_CYCLES    = 160;
    // Busy span plus drain pause plus sender gaps, taken several times over
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int COEF_SPAN       = 16384;
    localparam int SAMPLE_SPAN     = 131072;
    localparam logic [dss_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    dss_pkg::req_t                   request;
    logic                            result_valid;
    dss_pkg::res_t                   result;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [dss_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [dss_pkg::CFG_DATA_W-1:0]  cfg_data;
    int                              pending;
    int                              fail_count;

    // Stimulus-side view of sizes and of which stores hold data
    int unsigned            nx;
    int unsigned            nu;
    int unsigned            ny;
    bit                     coef_loaded [STORE_DEPTH];
    bit                     u_loaded [4];
    int unsigned            u_taken;
    int                     idle_pct;
    int                     items_sent;
    int                     watchdog = 0;

    discrete_state_space_system uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    dss_output_check output_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pending      (pending),
        .fail_count   (fail_count)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready) || result_valid)
            watchdog <= 0;
        else if (watchdog >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            watchdog <= watchdog + 1;
    end

    // Mostly small Q16.16 values, with the extremes and full-range words mixed in
    function automatic logic signed [31:0] rand_q16(input int unsigned span);
        case ($urandom_range(0, 15))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return $urandom;
            default: return int'($urandom_range(0, 2 * span)) - int'(span);
        endcase
    endfunction

    // Present one request, after a random gap, and hold it until taken
    task automatic send_req(input dss_pkg::req_t r);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic write_coef(input int unsigned idx, input logic signed [31:0] val,
                              input bit last);
        dss_pkg::req_t r;
        r.kind       = dss_pkg::KIND_COEF;
        r.coef_index = 8'(idx);
        r.value      = val;
        r.last_input = last;
        send_req(r);
        if (idx < STORE_DEPTH)
            coef_loaded[idx] = 1'b1;
    endtask

    task automatic send_sample(input logic signed [31:0] val, input bit last);
        dss_pkg::req_t r;
        r.kind       = dss_pkg::KIND_SAMPLE;
        r.coef_index = 8'($urandom_range(0, 255));
        r.value      = val;
        r.last_input = last;
        send_req(r);
        if (u_taken < nu)
        begin
            u_loaded[u_taken] = 1'b1;
            u_taken++;
        end
        if (last)
            u_taken = 0;
    endtask

    // Fill every store entry the current sizes read that was never written
    task automatic load_missing_coefs();
        int unsigned total;
        total = nx * nx + nx * nu + ny * nx + ny * nu;
        for (int unsigned i = 0; i < total; i++)
            if (!coef_loaded[i])
                write_coef(i, rand_q16(COEF_SPAN), $urandom_range(0, 1));
    endtask

    // One step of count samples, the last one closing it
    task automatic run_step(input int unsigned count);
        for (int unsigned k = 0; k < count; k++)
        begin
            if (k == count - 1)
                load_missing_coefs();
            send_sample(rand_q16(SAMPLE_SPAN), k == count - 1);
        end
    endtask

    task automatic random_phase(input int n_items);
        int  stop_at;
        bit  short_ok;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            short_ok = (nu >= 2);
            for (int unsigned k = 0; k < nu; k++)
                if (!u_loaded[k])
                    short_ok = 1'b0;
            case ($urandom_range(0, 9))
                0: write_coef($urandom_range(0, 255), rand_q16(COEF_SPAN), $urandom_range(0, 1));
                1: run_step(nu + 1 + $urandom_range(0, 1));
                2:
                begin
                    if (short_ok)
                        run_step($urandom_range(1, nu - 1));
                    else
                        run_step((nu == 0) ? 1 : nu);
                end
                default: run_step((nu == 0) ? 1 : nu);
            endcase
        end
    endtask

    // Drop start and hold until every predicted result is back and the block is quiet
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_cfg(input logic [dss_pkg::CFG_IDX_W-1:0] idx, input logic [3:0] low);
        logic [dss_pkg::CFG_DATA_W-1:0] word;
        word = $urandom;
        if (idx == dss_pkg::CFG_STATES)
            word[3:0] = low;
        else
            word[2:0] = low[2:0];
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_sizes(input logic [3:0] s, input logic [2:0] i, input logic [2:0] o,
                             input bit touch_unused);
        write_cfg(dss_pkg::CFG_STATES, s);
        write_cfg(dss_pkg::CFG_INPUTS, {1'b0, i});
        write_cfg(dss_pkg::CFG_OUTPUTS, {1'b0, o});
        if (touch_unused)
            write_cfg(CFG_UNUSED, 4'($urandom));
        cfg_valid <= 1'b0;
        nx = (s > 8) ? 8 : s;
        nu = (i > 4) ? 4 : i;
        ny = (o > 4) ? 4 : o;
    endtask

    initial
    begin
        logic [3:0] s;
        logic [2:0] i;
        logic [2:0] o;
        rst_n      = 1'b0;
        start      = 1'b0;
        request    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        nx         = 8;
        nu         = 4;
        ny         = 4;
        u_taken    = 0;
        idle_pct   = 0;
        items_sent = 0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: load the store at full size, then push the edges
        load_missing_coefs();
        write_coef(STORE_DEPTH, 32'sh7FFF_FFFF, 1'b1);
        write_coef(255, 32'sh8000_0000, 1'b0);
        // First row of D at full scale: y0 runs the 64-bit sum into its upper bound
        for (int unsigned k = 0; k < 4; k++)
            write_coef(128 + 4 * k, 32'sh7FFF_FFFF, 1'b0);
        for (int unsigned k = 0; k < 4; k++)
            send_sample(32'sh7FFF_FFFF, k == 3);
        // Same row at the negative extreme drives the sum to its lower bound
        for (int unsigned k = 0; k < 4; k++)
            write_coef(128 + 4 * k, 32'sh8000_0000, 1'b0);
        for (int unsigned k = 0; k < 4; k++)
            send_sample(32'sh7FFF_FFFF, k == 3);
        // Extra element beyond nu, closing after four others
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sh0000_0000, 1'b0);
        send_sample(32'sh0001_0000, 1'b0);
        send_sample(-32'sh0000_8000, 1'b0);
        send_sample(32'sh7FFF_FFFF, 1'b1);
        // Short step reuses the buffered tail
        send_sample(32'sh0000_8000, 1'b0);
        send_sample(-32'sh0001_0000, 1'b1);

        random_phase(ITEMS_PER_PHASE);
        drain();

        // Walk through size settings, extremes first
        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            case (p)
                0:       begin s = 4'd0;  i = 3'd4; o = 3'd4; end
                1:       begin s = 4'd8;  i = 3'd0; o = 3'd4; end
                2:       begin s = 4'd8;  i = 3'd4; o = 3'd0; end
                3:       begin s = 4'd0;  i = 3'd0; o = 3'd2; end
                4:       begin s = 4'd15; i = 3'd7; o = 3'd7; end
                5:       begin s = 4'd1;  i = 3'd1; o = 3'd1; end
                6:       begin s = 4'd3;  i = 3'd2; o = 3'd3; end
                7:       begin s = 4'd0;  i = 3'd0; o = 3'd0; end
                8:       begin s = 4'd8;  i = 3'd4; o = 3'd4; end
                default:
                begin
                    s = 4'($urandom_range(0, 15));
                    i = 3'($urandom_range(0, 7));
                    o = 3'($urandom_range(1, 7));
                end
            endcase
            case (p % 4)
                1:       idle_pct = 64;
                3:       idle_pct = 38;
                default: idle_pct = 0;
            endcase
            set_sizes(s, i, o, p == 4);
            random_phase(ITEMS_PER_PHASE);
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
